// ----- design/lpht_pkg.sv -----
// shared types and constants for the linear probing hash table
package lpht_pkg;

    localparam int REQ_W  = 2;
    localparam int KEY_W  = 44;
    localparam int REC_W  = 32;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 8;
    localparam int COLL_W = 16;
    localparam int CFG_W  = 9;

    localparam logic [CFG_W-1:0]  CFG_SIZE_RESET = 9'd256;
    localparam logic [COLL_W-1:0] COLL_MAX       = 16'hFFFF;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DELETED   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_DEL_MISS  = 3'd5;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic sum_step;
        logic mod_step;
        logic probe;
        logic finish;
    } lpht_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic sum_last;
        logic mod_last;
        logic hit;
        logic miss;
        logic out_free;
    } lpht_sts_t;

endpackage

// ----- design/lpht_ram.sv -----
// generic simple dual port ram with registered read
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lpht_ctrl.sv -----
// request sequencer for the hash table: clear, hash, modulo, probe, finish
module lpht_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               in_ready,
    input  lpht_pkg::lpht_sts_t sts,
    output lpht_pkg::lpht_cmd_t cmd
);
    import lpht_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SUM    = 3'd2;
    localparam logic [2:0] ST_MOD    = 3'd3;
    localparam logic [2:0] ST_PROBE  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (sts.sum_last) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                cmd.probe = 1'b1;
                if (sts.hit || sts.miss) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // result register must be empty or draining this cycle
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/lpht_dp.sv -----
// hash table datapath: digit sum, modulo, probe pipeline, slot rams, result register
module lpht_dp #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_DIGITS  = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lpht_pkg::lpht_cmd_t          cmd,
    output lpht_pkg::lpht_sts_t          sts,
    input  logic                         cfg_valid,
    input  logic [lpht_pkg::CFG_W-1:0]   cfg_data,
    input  logic [lpht_pkg::REQ_W-1:0]   req_type,
    input  logic [lpht_pkg::KEY_W-1:0]   key_digits,
    input  logic [lpht_pkg::REC_W-1:0]   record_handle,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lpht_pkg::STAT_W-1:0]  status,
    output logic [lpht_pkg::SLOT_W-1:0]  slot_index,
    output logic [lpht_pkg::REC_W-1:0]   record_out,
    output logic [lpht_pkg::COLL_W-1:0]  collision_total
);
    import lpht_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int SW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
    localparam int HW = $clog2(KEY_DIGITS * 63 + 1);
    localparam int DW = $clog2(KEY_DIGITS + 1);
    localparam int MW = $clog2(HW + 1);
    localparam int KVW = KEY_W + 1;

    // configuration
    logic [CFG_W-1:0] table_size_reg;
    logic [SW-1:0]    cfg_ext;
    logic [SW-1:0]    live_size;

    // request
    logic [REQ_W-1:0] req_reg;
    logic [KEY_W-1:0] key_reg;
    logic [REC_W-1:0] rec_reg;
    logic [SW-1:0]    size_reg;
    logic             is_ins;
    logic             is_del;

    // hashing
    logic [KEY_W-1:0] hsh_key_reg;
    logic [HW-1:0]    sum_reg;
    logic [DW-1:0]    dig_cnt_reg;
    logic [MW-1:0]    mod_cnt_reg;
    logic [SW-1:0]    rem_reg;
    logic [SW:0]      rem_shift;
    logic [SW-1:0]    rem_next;

    // probe pipeline
    logic [IW-1:0] iss_idx_reg;
    logic [SW-1:0] iss_cnt_reg;
    logic          iss_wrapped_reg;
    logic [SW-1:0] iss_step;
    logic          iss_wrap;
    logic          can_issue;
    logic          chk_valid_reg;
    logic [IW-1:0] chk_idx_reg;
    logic [SW-1:0] chk_n_reg;
    logic          chk_wrapped_reg;
    logic          hit;
    logic          miss;

    // memories
    logic [KVW-1:0]   kv_rdata;
    logic [REC_W-1:0] rec_rdata;
    logic             kv_we;
    logic [IW-1:0]    kv_waddr;
    logic [KVW-1:0]   kv_wdata;
    logic             rec_we;
    logic [IW-1:0]    clr_idx_reg;

    // probe result
    logic             res_found_reg;
    logic [IW-1:0]    res_idx_reg;
    logic [SW-1:0]    res_n_reg;
    logic             res_wrap_reg;
    logic [REC_W-1:0] res_rec_reg;

    // collision count and result register
    logic [COLL_W-1:0]    coll_reg;
    logic [SW:0]          coll_amount;
    logic [COLL_W:0]      coll_sum;
    logic [COLL_W-1:0]    coll_next;
    logic [STAT_W-1:0]    stat_next;
    logic [IW+SLOT_W-1:0] slot_wide;
    logic                 m_valid_reg;
    logic [STAT_W-1:0]    out_stat_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [REC_W-1:0]     out_rec_reg;
    logic [COLL_W-1:0]    out_coll_reg;

    assign cfg_ext   = SW'(table_size_reg);
    assign live_size = (cfg_ext == '0) ? SW'(1) :
                       (cfg_ext > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : cfg_ext;

    assign is_ins = (req_reg == REQ_INSERT);
    assign is_del = (req_reg == REQ_DELETE);

    // restoring remainder, one sum bit per cycle
    assign rem_shift = {rem_reg, sum_reg[HW-1]};
    assign rem_next  = (rem_shift >= {1'b0, size_reg}) ?
                       SW'(rem_shift - {1'b0, size_reg}) : rem_shift[SW-1:0];

    assign iss_step  = SW'(iss_idx_reg) + SW'(1);
    assign iss_wrap  = (iss_step == size_reg);
    assign can_issue = (iss_cnt_reg < size_reg);

    // insert looks for a free slot, find and delete for a live matching key
    assign hit  = chk_valid_reg && (is_ins ? !kv_rdata[KEY_W] :
                  (kv_rdata[KEY_W] && (kv_rdata[KEY_W-1:0] == key_reg)));
    assign miss = !chk_valid_reg && !can_issue;

    assign sts.clear_last = (clr_idx_reg == IW'(TABLE_DEPTH - 1));
    assign sts.sum_last   = (dig_cnt_reg == DW'(KEY_DIGITS - 1));
    assign sts.mod_last   = (mod_cnt_reg == MW'(HW - 1));
    assign sts.hit        = hit;
    assign sts.miss       = miss;
    assign sts.out_free   = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= CFG_SIZE_RESET;
            clr_idx_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                table_size_reg <= cfg_data;
            end
            if (cmd.clear_step) begin
                clr_idx_reg <= clr_idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg     <= req_type;
            key_reg     <= key_digits;
            rec_reg     <= record_handle;
            hsh_key_reg <= key_digits;
            size_reg    <= live_size;
            sum_reg     <= '0;
            rem_reg     <= '0;
            dig_cnt_reg <= '0;
            mod_cnt_reg <= '0;
        end
        if (cmd.sum_step) begin
            sum_reg     <= sum_reg + HW'(48) + HW'(hsh_key_reg[3:0]);
            hsh_key_reg <= {4'd0, hsh_key_reg[KEY_W-1:4]};
            dig_cnt_reg <= dig_cnt_reg + DW'(1);
        end
        if (cmd.mod_step) begin
            rem_reg     <= rem_next;
            sum_reg     <= {sum_reg[HW-2:0], 1'b0};
            mod_cnt_reg <= mod_cnt_reg + MW'(1);
            if (sts.mod_last) begin
                iss_idx_reg     <= rem_next[IW-1:0];
                iss_cnt_reg     <= '0;
                iss_wrapped_reg <= 1'b0;
                chk_valid_reg   <= 1'b0;
            end
        end
        if (cmd.probe) begin
            if (can_issue) begin
                iss_idx_reg     <= iss_wrap ? '0 : iss_step[IW-1:0];
                iss_cnt_reg     <= iss_cnt_reg + SW'(1);
                iss_wrapped_reg <= iss_wrapped_reg | iss_wrap;
                chk_valid_reg   <= 1'b1;
                chk_idx_reg     <= iss_idx_reg;
                chk_n_reg       <= iss_cnt_reg;
                chk_wrapped_reg <= iss_wrapped_reg;
            end else begin
                chk_valid_reg <= 1'b0;
            end
            if (hit || miss) begin
                res_found_reg <= hit;
                res_idx_reg   <= chk_idx_reg;
                res_n_reg     <= chk_n_reg;
                res_wrap_reg  <= chk_wrapped_reg;
                res_rec_reg   <= rec_rdata;
            end
        end
    end

    // slot state: valid bit with the key, record alongside
    assign kv_we    = cmd.clear_step || (cmd.finish && res_found_reg && (is_ins || is_del));
    assign kv_waddr = cmd.clear_step ? clr_idx_reg : res_idx_reg;
    assign kv_wdata = cmd.clear_step ? '0 : {is_ins, key_reg};
    assign rec_we   = cmd.finish && res_found_reg && is_ins;

    lpht_ram #(
        .WIDTH (KVW),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (kv_wdata),
        .re    (cmd.probe),
        .raddr (iss_idx_reg),
        .rdata (kv_rdata)
    );

    lpht_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (res_idx_reg),
        .wdata (rec_reg),
        .re    (cmd.probe),
        .raddr (iss_idx_reg),
        .rdata (rec_rdata)
    );

    // insert collisions: occupied slots passed plus one on wrap, full table adds size + 1
    always_comb begin
        coll_amount = '0;
        if (is_ins) begin
            if (!res_found_reg) begin
                coll_amount = {1'b0, size_reg} + (SW + 1)'(1);
            end else if (res_n_reg != '0) begin
                coll_amount = {1'b0, res_n_reg} + (SW + 1)'(res_wrap_reg);
            end
        end
    end

    assign coll_sum  = {1'b0, coll_reg} + (COLL_W + 1)'(coll_amount);
    assign coll_next = (coll_sum > {1'b0, COLL_MAX}) ? COLL_MAX : coll_sum[COLL_W-1:0];

    always_comb begin
        unique case (req_reg)
            REQ_INSERT: stat_next = res_found_reg ? STAT_INSERTED : STAT_FULL;
            REQ_DELETE: stat_next = res_found_reg ? STAT_DELETED : STAT_DEL_MISS;
            REQ_FIND:   stat_next = res_found_reg ? STAT_FOUND : STAT_NOT_FOUND;
            default:    stat_next = res_found_reg ? STAT_FOUND : STAT_NOT_FOUND;
        endcase
    end

    assign slot_wide = {{SLOT_W{1'b0}}, res_idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            coll_reg    <= '0;
        end else begin
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
                coll_reg    <= coll_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_stat_reg <= stat_next;
            out_slot_reg <= res_found_reg ? slot_wide[SLOT_W-1:0] : '0;
            out_rec_reg  <= (res_found_reg && !is_ins && !is_del) ? res_rec_reg : '0;
            out_coll_reg <= coll_next;
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign status          = out_stat_reg;
    assign slot_index      = out_slot_reg;
    assign record_out      = out_rec_reg;
    assign collision_total = out_coll_reg;

    a_home_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_step && sts.mod_last |-> rem_next < size_reg)
        else $error("home slot not below table size");

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.probe && chk_valid_reg |-> SW'(chk_idx_reg) < size_reg)
        else $error("probe address beyond table size");

    a_coll_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> coll_reg >= $past(coll_reg))
        else $error("collision count decreased");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_tready))
        else $error("result loaded over an untaken result");

endmodule

// ----- design/linear_probe_hash_table_core.sv -----
// Open-addressing hash table keyed by a BCD phone number, with linear probing.
// After reset the block sweeps the key memory once to clear every slot, one slot
// per cycle; s_tready stays low until then, configuration writes are taken
// throughout. One request is handled at a time: accept, a digit sum over the
// KEY_DIGITS key digits, a bit-serial modulo by the table size, then one slot
// read per cycle from the key/record memories until a hit or until every slot
// has been checked, then the result load. The single read port of the slot
// memories sets the probe rate. A finished result waits in an output register
// while the next request is taken.
module linear_probe_hash_table_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_DIGITS  = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    // table_size
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // key_digits[43:0], record_handle[75:44], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // slot_index[7:0], record_out[39:8], collision_total[55:40]
    output logic [2:0]  m_tuser    // status[2:0]
);
    import lpht_pkg::*;

    lpht_cmd_t cmd;
    lpht_sts_t sts;

    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [REC_W-1:0]  record_out;
    logic [COLL_W-1:0] collision_total;

    assign cfg_ready = 1'b1;

    lpht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpht_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_DIGITS  (KEY_DIGITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .req_type        (s_tuser),
        .key_digits      (s_tdata[KEY_W-1:0]),
        .record_handle   (s_tdata[KEY_W+REC_W-1:KEY_W]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .status          (status),
        .slot_index      (slot_index),
        .record_out      (record_out),
        .collision_total (collision_total)
    );

    assign m_tdata = {collision_total, record_out, slot_index};
    assign m_tuser = status;

endmodule
